FILE: rtl/gtf_pkg.sv
// package for the grouped team fifo
// word types, action codes and default sizes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gtf_pkg;

    localparam int unsigned MEMBERS_DEF = 1024;
    localparam int unsigned TEAMS_DEF   = 16;
    localparam int unsigned NODES_DEF   = 1024;

    typedef enum logic [1:0] {
        ACT_ASSIGN = 2'd0,
        ACT_ARRIVE = 2'd1,
        ACT_SERVE  = 2'd2,
        ACT_CLOSE  = 2'd3
    } act_t;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] member_id;
        logic [3:0] team_id;
    } in_word_t;

    typedef struct packed {
        logic [9:0] served_member;
        logic       line_empty;
    } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/gtf_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gtf_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/grouped_team_fifo.sv
// grouped team fifo, one word in flight: assign, close and a dropped arrive stay in idle;
// arrive steps through arr1, arr2; serve through srv1, srv2, srv3, or straight to srv3
// on an empty line (plus any wait for the result register). the served word is
// registered as srv3 fires. dependent reads: membership -> team tail, line -> team
// head/tail -> node. reset: synchronous active low; afterwards a clearing pass over
// every member zeroes the membership memory while s_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module grouped_team_fifo
    import gtf_pkg::*;
#(
    parameter int unsigned MEMBERS = MEMBERS_DEF,
    parameter int unsigned TEAMS   = TEAMS_DEF,
    parameter int unsigned NODES   = NODES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    localparam int unsigned MAW = $clog2(MEMBERS);
    localparam int unsigned TW  = $clog2(TEAMS);
    localparam int unsigned NW  = $clog2(NODES);
    localparam int unsigned CW  = $clog2(TEAMS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ARR1 = 6'b000010,
        ST_ARR2 = 6'b000100,
        ST_SRV1 = 6'b001000,
        ST_SRV2 = 6'b010000,
        ST_SRV3 = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic            clr_reg;
    logic [MAW:0]    clr_cnt_reg;
    logic [NW:0]     fc_reg;
    logic [NW:0]     lw_reg;
    logic [TEAMS-1:0] wait_reg;
    logic [TW-1:0]   lh_reg;
    logic [CW-1:0]   lc_reg;
    logic            m_valid_reg;
    out_word_t       m_data_reg;
    logic [9:0]      member_reg;
    logic            in_rng_reg;
    logic            empty_reg;
    logic [TW-1:0]   t_reg;
    logic [NW-1:0]   n_reg;
    logic [NW-1:0]   pi_reg;

    logic [TW-1:0]   mt_q, tl_q;
    logic [NW-1:0]   fs_q, th_q, tt_q, nl_q;
    logic [9:0]      nm_q;

    logic            acc, fire;
    logic [10:0]     tmod;
    logic [TW-1:0]   team_w;
    logic [TW-1:0]   arr_t;
    logic [NW-1:0]   pop_idx, pop_n;
    logic [TW:0]     lsum;
    logic [TW-1:0]   ltail;
    logic            is_last;

    assign s_ready = (state_reg == ST_IDLE) && !clr_reg;
    assign acc     = s_valid && s_ready;
    assign fire    = (state_reg == ST_SRV3) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // team id modulo team count
    always_comb begin
        tmod = {7'd0, s_data.team_id};
        for (int i = 0; i < 8; i++) begin
            if (tmod >= 11'(TEAMS)) begin
                tmod = tmod - 11'(TEAMS);
            end
        end
        team_w = TW'(tmod);
    end

    // free stack pop, slots below the low mark still hold their reset order
    assign pop_idx = NW'(fc_reg - 1'b1);
    assign arr_t   = in_rng_reg ? mt_q : '0;
    assign pop_n   = ({1'b0, pi_reg} < lw_reg) ? NW'(NODES - 1 - pi_reg) : fs_q;

    // tail slot of the line of teams
    always_comb begin
        lsum = (TW + 1)'(lh_reg) + (TW + 1)'(lc_reg);
        if (lsum >= (TW + 1)'(TEAMS)) begin
            lsum = lsum - (TW + 1)'(TEAMS);
        end
        ltail = TW'(lsum);
    end

    assign is_last = (n_reg == tt_q);

    // memories
    gtf_ram #(.DEPTH(MEMBERS), .WIDTH(TW)) u_member_team (
        .aclk  (aclk),
        .we    (clr_reg || (acc && s_data.action == ACT_ASSIGN
                            && 32'(s_data.member_id) < MEMBERS)),
        .waddr (clr_reg ? clr_cnt_reg[MAW-1:0] : MAW'(s_data.member_id)),
        .wdata (clr_reg ? '0 : team_w),
        .re    (acc),
        .raddr (MAW'(s_data.member_id)),
        .rdata (mt_q)
    );

    gtf_ram #(.DEPTH(NODES), .WIDTH(NW)) u_free_slots (
        .aclk  (aclk),
        .we    (fire && !empty_reg && fc_reg < (NW + 1)'(NODES)),
        .waddr (fc_reg[NW-1:0]),
        .wdata (n_reg),
        .re    (acc),
        .raddr (pop_idx),
        .rdata (fs_q)
    );

    gtf_ram #(.DEPTH(TEAMS), .WIDTH(TW)) u_team_line (
        .aclk  (aclk),
        .we    (state_reg == ST_ARR2 && !wait_reg[t_reg] && lc_reg < CW'(TEAMS)),
        .waddr (ltail),
        .wdata (t_reg),
        .re    (acc),
        .raddr (lh_reg),
        .rdata (tl_q)
    );

    gtf_ram #(.DEPTH(TEAMS), .WIDTH(NW)) u_team_head (
        .aclk  (aclk),
        .we    ((state_reg == ST_ARR2 && !wait_reg[t_reg])
                || (fire && !empty_reg && !is_last)),
        .waddr (t_reg),
        .wdata (state_reg == ST_ARR2 ? n_reg : nl_q),
        .re    (state_reg == ST_SRV1),
        .raddr (tl_q),
        .rdata (th_q)
    );

    gtf_ram #(.DEPTH(TEAMS), .WIDTH(NW)) u_team_tail (
        .aclk  (aclk),
        .we    (state_reg == ST_ARR2),
        .waddr (t_reg),
        .wdata (n_reg),
        .re    (state_reg == ST_SRV1 || state_reg == ST_ARR1),
        .raddr (state_reg == ST_SRV1 ? tl_q : arr_t),
        .rdata (tt_q)
    );

    gtf_ram #(.DEPTH(NODES), .WIDTH(10)) u_node_member (
        .aclk  (aclk),
        .we    (state_reg == ST_ARR2),
        .waddr (n_reg),
        .wdata (member_reg),
        .re    (state_reg == ST_SRV2),
        .raddr (th_q),
        .rdata (nm_q)
    );

    gtf_ram #(.DEPTH(NODES), .WIDTH(NW)) u_node_link (
        .aclk  (aclk),
        .we    (state_reg == ST_ARR2 && wait_reg[t_reg]),
        .waddr (tt_q),
        .wdata (n_reg),
        .re    (state_reg == ST_SRV2),
        .raddr (th_q),
        .rdata (nl_q)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc && s_data.action == ACT_ARRIVE && fc_reg != '0) begin
                    state_next = ST_ARR1;
                end else if (acc && s_data.action == ACT_SERVE) begin
                    state_next = (lc_reg == '0) ? ST_SRV3 : ST_SRV1;
                end
            end
            ST_ARR1: state_next = ST_ARR2;
            ST_ARR2: state_next = ST_IDLE;
            ST_SRV1: state_next = ST_SRV2;
            ST_SRV2: state_next = ST_SRV3;
            ST_SRV3: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            fc_reg      <= (NW + 1)'(NODES);
            lw_reg      <= (NW + 1)'(NODES);
            wait_reg    <= '0;
            lh_reg      <= '0;
            lc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // membership clearing pass
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (MAW + 1)'(MEMBERS - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            // close empties every queue
            if (acc && s_data.action == ACT_CLOSE) begin
                fc_reg   <= (NW + 1)'(NODES);
                lw_reg   <= (NW + 1)'(NODES);
                wait_reg <= '0;
                lh_reg   <= '0;
                lc_reg   <= '0;
            end
            // arrival commit
            if (state_reg == ST_ARR2) begin
                fc_reg <= fc_reg - 1'b1;
                if ({1'b0, pi_reg} < lw_reg) begin
                    lw_reg <= {1'b0, pi_reg};
                end
                if (!wait_reg[t_reg]) begin
                    wait_reg[t_reg] <= 1'b1;
                    if (lc_reg < CW'(TEAMS)) begin
                        lc_reg <= lc_reg + 1'b1;
                    end
                end
            end
            // serve commit
            if (fire && !empty_reg) begin
                if (fc_reg < (NW + 1)'(NODES)) begin
                    fc_reg <= fc_reg + 1'b1;
                end
                if (is_last) begin
                    wait_reg[t_reg] <= 1'b0;
                    lh_reg <= (lh_reg == TW'(TEAMS - 1)) ? '0 : lh_reg + 1'b1;
                    lc_reg <= lc_reg - 1'b1;
                end
            end
            // result word handshake
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and pointer registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            member_reg <= s_data.member_id;
            in_rng_reg <= 32'(s_data.member_id) < MEMBERS;
            empty_reg  <= (lc_reg == '0);
            pi_reg     <= pop_idx;
        end
        if (state_reg == ST_ARR1) begin
            t_reg <= arr_t;
            n_reg <= pop_n;
        end
        if (state_reg == ST_SRV1) begin
            t_reg <= tl_q;
        end
        if (state_reg == ST_SRV2) begin
            n_reg <= th_q;
        end
        if (fire) begin
            m_data_reg.served_member <= empty_reg ? 10'd0 : nm_q;
            m_data_reg.line_empty    <= empty_reg;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for grouped_team_fifo: a predictor of the team queue checks every served word
// depends on rtl/gtf_pkg.sv, rtl/gtf_ram.sv and rtl/grouped_team_fifo.sv
`timescale 1ns / 1ps

module tb;
    import gtf_pkg::*;

    localparam int NODES = NODES_DEF;
    localparam int TEAMS = TEAMS_DEF;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    grouped_team_fifo uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // predictor state of the team queue
    logic [3:0]  q_member_team [1024];
    logic [9:0]  q_node_member [NODES];
    logic [9:0]  q_node_link   [NODES];
    logic [9:0]  q_free_slots  [NODES];
    logic [10:0] q_free_count;
    logic [9:0]  q_team_head   [TEAMS];
    logic [9:0]  q_team_tail   [TEAMS];
    logic        q_team_waiting[TEAMS];
    logic [3:0]  q_team_line   [TEAMS];
    logic [3:0]  q_line_head;
    logic [4:0]  q_line_count;

    out_word_t served_q[$];
    int errors = 0;
    int words_sent = 0;
    int served_seen = 0;
    int empty_seen = 0;
    int drops_seen = 0;
    bit quiet = 1'b0;
    bit stall_req = 1'b0;
    int hold_left = 0;

    function automatic void empty_all();
        for (int i = 0; i < NODES; i++) q_free_slots[i] = 10'(NODES - 1 - i);
        q_free_count = 11'(NODES);
        for (int i = 0; i < TEAMS; i++) q_team_waiting[i] = 1'b0;
        q_line_head  = '0;
        q_line_count = '0;
    endfunction

    // work out the effect of one accepted word
    function automatic void predict_team_queue(in_word_t w);
        logic [3:0] t;
        logic [9:0] n;
        out_word_t r;
        case (act_t'(w.action))
            ACT_ASSIGN: q_member_team[w.member_id] = w.team_id;
            ACT_ARRIVE: begin
                t = q_member_team[w.member_id];
                if (q_free_count == 0) begin
                    drops_seen++;
                end else begin
                    q_free_count--;
                    n = q_free_slots[q_free_count];
                    q_node_member[n] = w.member_id;
                    if (q_team_waiting[t]) begin
                        q_node_link[q_team_tail[t]] = n;
                        q_team_tail[t] = n;
                    end else begin
                        q_team_head[t] = n;
                        q_team_tail[t] = n;
                        q_team_waiting[t] = 1'b1;
                        if (q_line_count < TEAMS) begin
                            q_team_line[4'(q_line_head + q_line_count)] = t;
                            q_line_count++;
                        end
                    end
                end
            end
            ACT_SERVE: begin
                if (q_line_count == 0) begin
                    r.served_member = '0;
                    r.line_empty = 1'b1;
                end else begin
                    t = q_team_line[q_line_head];
                    n = q_team_head[t];
                    r.served_member = q_node_member[n];
                    r.line_empty = 1'b0;
                    if (q_free_count < NODES) begin
                        q_free_slots[q_free_count] = n;
                        q_free_count++;
                    end
                    if (n == q_team_tail[t]) begin
                        q_team_waiting[t] = 1'b0;
                        q_line_head++;
                        q_line_count--;
                    end else begin
                        q_team_head[t] = q_node_link[n];
                    end
                end
                served_q.push_back(r);
            end
            default: empty_all();
        endcase
    endfunction

    // offer one word, idling first at random
    task automatic send_word(act_t a, logic [9:0] m, logic [3:0] t);
        int gap;
        in_word_t w;
        w.action = a;
        w.member_id = m;
        w.team_id = t;
        gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_team_queue(w);
        words_sent++;
    endtask

    // receiver: random ready, long hold-off on request, check each served word
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (served_q.size() == 0) begin
                $error("served word with nothing expected");
                errors++;
            end else begin
                if (m_data.served_member !== served_q[0].served_member) begin
                    $error("served_member expected %0d actual %0d",
                           served_q[0].served_member, m_data.served_member);
                    errors++;
                end
                if (m_data.line_empty !== served_q[0].line_empty) begin
                    $error("line_empty expected %0d actual %0d",
                           served_q[0].line_empty, m_data.line_empty);
                    errors++;
                end
                if (served_q[0].line_empty) empty_seen++;
                else served_seen++;
                void'(served_q.pop_front());
            end
        end
        if (stall_req && hold_left == 0) begin
            hold_left <= 300;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= (hold_left == 1);
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 30);
        end
    end

    // extremes of every field, each action, serve on an empty line
    task automatic test_directed();
        send_word(ACT_SERVE, 10'd0, 4'd0);
        send_word(ACT_ASSIGN, 10'd1023, 4'd15);
        send_word(ACT_ASSIGN, 10'd0, 4'd0);
        send_word(ACT_ASSIGN, 10'd5, 4'd15);
        send_word(ACT_ARRIVE, 10'd1023, 4'd0);
        send_word(ACT_ARRIVE, 10'd0, 4'd15);
        send_word(ACT_ARRIVE, 10'd5, 4'd0);
        send_word(ACT_ARRIVE, 10'd7, 4'd0);
        send_word(ACT_ARRIVE, 10'd1023, 4'd0);
        send_word(ACT_SERVE, 10'd0, 4'd0);
        send_word(ACT_SERVE, 10'd1023, 4'd15);
        send_word(ACT_SERVE, 10'd0, 4'd0);
        send_word(ACT_SERVE, 10'd0, 4'd0);
        send_word(ACT_SERVE, 10'd0, 4'd0);
        send_word(ACT_SERVE, 10'd0, 4'd0);
        send_word(ACT_ARRIVE, 10'd3, 4'd0);
        send_word(ACT_CLOSE, 10'd1023, 4'd15);
        send_word(ACT_SERVE, 10'd0, 4'd0);
    endtask

    // fill the node store so arrivals drop, then drain a few and close
    task automatic test_full_store();
        quiet = 1'b1;
        for (int i = 0; i < NODES + 8; i++)
            send_word(ACT_ARRIVE, 10'($urandom), 4'($urandom));
        quiet = 1'b0;
        for (int i = 0; i < 20; i++) send_word(ACT_SERVE, 10'($urandom), 4'($urandom));
        send_word(ACT_ARRIVE, 10'($urandom), 4'($urandom));
        send_word(ACT_CLOSE, 10'($urandom), 4'($urandom));
    endtask

    // receiver holds off while serves keep coming
    task automatic test_backpressure();
        for (int i = 0; i < 10; i++) send_word(ACT_ARRIVE, 10'($urandom), 4'($urandom));
        stall_req = 1'b1;
        for (int i = 0; i < 12; i++) send_word(ACT_SERVE, 10'($urandom), 4'($urandom));
        stall_req = 1'b0;
    endtask

    // random mix, mostly arrivals and serves over random members and teams
    task automatic test_random(int count);
        int p;
        for (int i = 0; i < count; i++) begin
            quiet = (i >= count / 2 && i < count / 2 + 200);
            p = $urandom_range(99);
            if (p < 13)
                send_word(ACT_ASSIGN, 10'($urandom), 4'($urandom));
            else if (p < 58)
                send_word(ACT_ARRIVE, 10'($urandom), 4'($urandom));
            else if (p < 98)
                send_word(ACT_SERVE, 10'($urandom), 4'($urandom));
            else
                send_word(ACT_CLOSE, 10'($urandom), 4'($urandom));
        end
        quiet = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 1024; i++) q_member_team[i] = '0;
        for (int i = 0; i < NODES; i++) begin
            q_node_member[i] = '0;
            q_node_link[i] = '0;
        end
        for (int i = 0; i < TEAMS; i++) begin
            q_team_head[i] = '0;
            q_team_tail[i] = '0;
            q_team_line[i] = '0;
        end
        empty_all();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random(1000);

        s_valid <= 1'b0;
        while (served_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d words: %0d members served, %0d empty serves, %0d dropped arrivals",
                 words_sent, served_seen, empty_seen, drops_seen);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule
